### hw/rtl/mandelbrot_escape_iteration_core_assert.svh
// Assertion macros for the escape-time core.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef MANDELBROT_ESCAPE_ITERATION_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mbe_pkg.sv
// Shared sizes, stage types and helpers for the escape-time core.
// No dependencies; imported by the cell, the chain and the top level.
package mbe_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;

  // Internal values are Q12.FRAC; live operands stay below 12 in magnitude.
  localparam int INT_W   = FRAC_BITS + 12;
  localparam int MAG_W   = FRAC_BITS + 4;
  localparam int PROD_W  = 2 * MAG_W + 2;
  localparam int SQ_W    = 2 * MAG_W - FRAC_BITS;
  localparam int DIGIT_W = 8;
  localparam int NCELLS  = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int BPAD_W  = NCELLS * DIGIT_W;

  localparam int NUM_LANES = 3;
  localparam int LANE_UU   = 0;
  localparam int LANE_VV   = 1;
  localparam int LANE_UV   = 2;

  localparam logic [INT_W-1:0]      FOUR_Q      = INT_W'(4) << FRAC_BITS;
  localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = COUNT_BITS'(100);

  typedef struct packed {
    logic [PROD_W-1:0] a;
    logic [BPAD_W-1:0] b;
    logic [PROD_W-1:0] acc;
  } mbe_lane_t;

  typedef struct packed {
    logic                       vld;
    mbe_lane_t [NUM_LANES-1:0]  lane;
  } mbe_stage_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } mbe_state_t;

  function automatic logic [MAG_W-1:0] mbe_mag(input logic [INT_W-1:0] x);
    logic [INT_W-1:0] n;
    n = x[INT_W-1] ? (~x + INT_W'(1)) : x;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] mbe_sext(input logic [INT_W-1:0] x);
    return {{(PROD_W-INT_W){x[INT_W-1]}}, x};
  endfunction

endpackage

### hw/rtl/mbe_cell.sv
// One digit cell of the multiplier chain: adds a times the low digit of b to the sum.
// Depends on mbe_pkg.
module mbe_cell
  import mbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mbe_stage_t stg_i,
  output mbe_stage_t stg_o
);

  logic                      vld_r;
  mbe_lane_t [NUM_LANES-1:0] lane_r;
  mbe_lane_t [NUM_LANES-1:0] lane_nxt;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      // shift the operands so the next cell sees the next digit at the same place
      lane_nxt[i].a   = stg_i.lane[i].a << DIGIT_W;
      lane_nxt[i].b   = stg_i.lane[i].b >> DIGIT_W;
      lane_nxt[i].acc = PROD_W'($signed(stg_i.lane[i].acc) +
                        $signed(stg_i.lane[i].a) *
                        $signed({1'b0, stg_i.lane[i].b[DIGIT_W-1:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= stg_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign stg_o.vld  = vld_r;
  assign stg_o.lane = lane_r;

endmodule

### hw/rtl/mbe_chain.sv
// Row of digit cells forming a pipelined three-lane multiplier.
// Depends on mbe_pkg and mbe_cell.
module mbe_chain
  import mbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mbe_stage_t stg_i,
  output mbe_stage_t stg_o
);

  mbe_stage_t stg [NCELLS+1];

  assign stg[0] = stg_i;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    mbe_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stg_i (stg[k]),
      .stg_o (stg[k+1])
    );
  end

  assign stg_o = stg[NCELLS];

endmodule

### hw/rtl/mandelbrot_escape_iteration_core.sv
// Escape-time core: iterates z = z*z + c for one point and reports count and escape.
// Depends on mbe_pkg, mbe_chain and mandelbrot_escape_iteration_core_assert.svh.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  input   | start, busy             | in_c_real, in_c_imag
//  result  | out_valid (1-cycle)     | out_iteration_count, out_escaped
//  config  | cfg_valid, cfg_ready    | cfg_max_iterations
//
// A pass issues the operands, then waits while they cross the digit cells of the chain.
// A point holds busy for all its passes; the result strobes in the cycle busy drops,
// and a new start can be taken in that same cycle.
// Synchronous reset sets the limit to 100 and idles the core; cfg_ready is always high.
// The receiver cannot stall: each result is shown for one cycle only.
`include "mandelbrot_escape_iteration_core_assert.svh"

module mandelbrot_escape_iteration_core
  import mbe_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_c_real,
  input  logic signed [COORD_BITS-1:0] in_c_imag,
  output logic                         out_valid,
  output logic [COUNT_BITS-1:0]        out_iteration_count,
  output logic                         out_escaped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [COUNT_BITS-1:0]        cfg_max_iterations
);

  mbe_state_t state_r, state_nxt;

  logic [INT_W-1:0]      u_r, u_nxt;
  logic [INT_W-1:0]      v_r, v_nxt;
  logic [COORD_BITS-1:0] re_r, re_nxt;
  logic [COORD_BITS-1:0] im_r, im_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] max_iter_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;
  logic                  out_esc_r, out_esc_nxt;

  mbe_stage_t chain_i, chain_o;

  logic [MAG_W-1:0]        u_mag, v_mag;
  logic [INT_W-1:0]        uv_a;
  logic [INT_W-1:0]        u2, v2, mag_sum, uv_q;
  logic signed [PROD_W-1:0] uv_full;
  logic [INT_W-1:0]        re_ext, im_ext;
  logic [COUNT_BITS-1:0]   pass_cnt;
  logic                    esc, done;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);

  // Operands for u*u, v*v and u*v; the sign of v is folded into the multiplicand.
  always_comb begin
    u_mag = mbe_mag(u_r);
    v_mag = mbe_mag(v_r);
    uv_a  = v_r[INT_W-1] ? (~u_r + INT_W'(1)) : u_r;

    chain_i.vld                 = (state_r == ST_ISSUE);
    chain_i.lane[LANE_UU].a     = PROD_W'(u_mag);
    chain_i.lane[LANE_UU].b     = BPAD_W'(u_mag);
    chain_i.lane[LANE_UU].acc   = '0;
    chain_i.lane[LANE_VV].a     = PROD_W'(v_mag);
    chain_i.lane[LANE_VV].b     = BPAD_W'(v_mag);
    chain_i.lane[LANE_VV].acc   = '0;
    chain_i.lane[LANE_UV].a     = mbe_sext(uv_a);
    chain_i.lane[LANE_UV].b     = BPAD_W'(v_mag);
    chain_i.lane[LANE_UV].acc   = '0;
  end

  mbe_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .stg_i (chain_i),
    .stg_o (chain_o)
  );

  always_comb begin
    u2      = INT_W'(chain_o.lane[LANE_UU].acc[FRAC_BITS +: SQ_W]);
    v2      = INT_W'(chain_o.lane[LANE_VV].acc[FRAC_BITS +: SQ_W]);
    // 2*u*v, floored
    uv_full = $signed(chain_o.lane[LANE_UV].acc) >>> (FRAC_BITS - 1);
    uv_q    = uv_full[INT_W-1:0];
    re_ext  = {{(INT_W-COORD_BITS){re_r[COORD_BITS-1]}}, re_r};
    im_ext  = {{(INT_W-COORD_BITS){im_r[COORD_BITS-1]}}, im_r};
    mag_sum = u2 + v2;
    esc     = (mag_sum >= FOUR_Q);
    pass_cnt = count_r + COUNT_BITS'(1);
    done    = esc || (pass_cnt >= max_iter_r);
  end

  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    out_esc_nxt   = out_esc_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // first pass from z = 0 lands directly on z = c
          re_nxt    = in_c_real;
          im_nxt    = in_c_imag;
          u_nxt     = {{(INT_W-COORD_BITS){in_c_real[COORD_BITS-1]}}, in_c_real};
          v_nxt     = {{(INT_W-COORD_BITS){in_c_imag[COORD_BITS-1]}}, in_c_imag};
          count_nxt = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (chain_o.vld) begin
          count_nxt = pass_cnt;
          u_nxt     = u2 - v2 + re_ext;
          v_nxt     = uv_q + im_ext;
          if (done) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = pass_cnt;
            out_esc_nxt   = esc;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      max_iter_r  <= MAX_ITER_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_iter_r <= cfg_max_iterations;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    re_r        <= re_nxt;
    im_r        <= im_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
    out_esc_r   <= out_esc_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_escaped         = out_esc_r;

  `MBE_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while still busy")
  `MBE_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted point did not raise busy")
  `MBE_ASSERT_IMP(a_chain_wait, chain_o.vld, state_r == ST_WAIT, "chain result outside wait")
  `MBE_ASSERT_IMP(a_count_nz, out_valid, out_iteration_count != '0, "zero pass count reported")

endmodule
